[sv/cst_pkg.sv]
// Package for the character stream tokenizer: token types, codes and byte classes.
`default_nettype none

package cst_pkg;

  // Output field widths
  localparam int OUT_W      = 16;
  localparam int TYPE_W     = 4;

  // Token queue depth between the scanner and the token channel
  localparam int QUEUE_DEPTH = 4;

  // Token type codes
  localparam logic [TYPE_W-1:0] TT_EOF       = 4'd0;
  localparam logic [TYPE_W-1:0] TT_PLUS      = 4'd1;
  localparam logic [TYPE_W-1:0] TT_MINUS     = 4'd2;
  localparam logic [TYPE_W-1:0] TT_STAR      = 4'd3;
  localparam logic [TYPE_W-1:0] TT_SLASH     = 4'd4;
  localparam logic [TYPE_W-1:0] TT_LPAREN    = 4'd5;
  localparam logic [TYPE_W-1:0] TT_RPAREN    = 4'd6;
  localparam logic [TYPE_W-1:0] TT_LBRACE    = 4'd7;
  localparam logic [TYPE_W-1:0] TT_RBRACE    = 4'd8;
  localparam logic [TYPE_W-1:0] TT_SEMICOLON = 4'd9;
  localparam logic [TYPE_W-1:0] TT_EQUAL     = 4'd10;
  localparam logic [TYPE_W-1:0] TT_STRING    = 4'd11;
  localparam logic [TYPE_W-1:0] TT_IDENT     = 4'd12;
  localparam logic [TYPE_W-1:0] TT_NUMBER    = 4'd13;

  // Byte constants
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_EQUAL  = 8'h3D;
  localparam logic [7:0] CH_UC_A   = 8'h41;
  localparam logic [7:0] CH_UC_Z   = 8'h5A;
  localparam logic [7:0] CH_USCORE = 8'h5F;
  localparam logic [7:0] CH_LC_A   = 8'h61;
  localparam logic [7:0] CH_LC_Z   = 8'h7A;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  // One token as it travels through the queue
  typedef struct packed {
    logic [TYPE_W-1:0] token_type;
    logic [OUT_W-1:0]  line_no;
    logic [OUT_W-1:0]  col_no;
    logic [OUT_W-1:0]  tok_len;
    logic              last_of_run;
  } tok_t;

  function automatic logic is_letter(logic [7:0] c);
    return ((c >= CH_LC_A) && (c <= CH_LC_Z)) || ((c >= CH_UC_A) && (c <= CH_UC_Z)) ||
           (c == CH_USCORE);
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  // Single-byte operator or bracket; TT_EOF means none
  function automatic logic [TYPE_W-1:0] single_type(logic [7:0] c);
    logic [TYPE_W-1:0] t;
    case (c)
      CH_PLUS:   t = TT_PLUS;
      CH_MINUS:  t = TT_MINUS;
      CH_STAR:   t = TT_STAR;
      CH_SLASH:  t = TT_SLASH;
      CH_LPAREN: t = TT_LPAREN;
      CH_RPAREN: t = TT_RPAREN;
      CH_LBRACE: t = TT_LBRACE;
      CH_RBRACE: t = TT_RBRACE;
      CH_SEMI:   t = TT_SEMICOLON;
      CH_EQUAL:  t = TT_EQUAL;
      default:   t = TT_EOF;
    endcase
    return t;
  endfunction

endpackage

`default_nettype wire

[sv/cst_char_if.sv]
// Byte channel interface: valid/ready handshake carrying one text byte.
`default_nettype none

interface cst_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;

  modport source (output valid, output ch, input ready);
  modport sink   (input valid, input ch, output ready);
endinterface

`default_nettype wire

[sv/cst_tok_if.sv]
// Token channel interface: valid/ready handshake carrying one token.
`default_nettype none

interface cst_tok_if;
  logic        valid;
  logic        ready;
  logic [3:0]  token_type;
  logic [15:0] line_no;
  logic [15:0] col_no;
  logic [15:0] tok_len;
  logic        last_of_run;

  modport source (output valid, output token_type, output line_no, output col_no,
                  output tok_len, output last_of_run, input ready);
  modport sink   (input valid, input token_type, input line_no, input col_no,
                  input tok_len, input last_of_run, output ready);
endinterface

`default_nettype wire

[sv/cst_tok_queue.sv]
// Token queue: takes up to two tokens per cycle, hands out one per ready cycle.
`default_nettype none

module cst_tok_queue (
  input  logic        clk,
  input  logic        rst,
  input  logic [1:0]  push_n,
  input  cst_pkg::tok_t push_a,
  input  cst_pkg::tok_t push_b,
  output logic        room2,
  cst_tok_if.source   tok_out
);
  import cst_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = PTR_W + 1;

  tok_t             entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;
  logic             pop;
  logic [PTR_W-1:0] wr_ptr_b;

  assign pop      = tok_out.valid && tok_out.ready;
  assign wr_ptr_b = wr_ptr + PTR_W'(1);
  assign room2    = (fill <= CNT_W'(QUEUE_DEPTH - 2));

  // Head of the queue drives the channel
  assign tok_out.valid       = (fill != '0);
  assign tok_out.token_type  = entries[rd_ptr].token_type;
  assign tok_out.line_no     = entries[rd_ptr].line_no;
  assign tok_out.col_no      = entries[rd_ptr].col_no;
  assign tok_out.tok_len     = entries[rd_ptr].tok_len;
  assign tok_out.last_of_run = entries[rd_ptr].last_of_run;

  // Token storage
  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      entries[wr_ptr] <= push_a;
    end
    if (push_n == 2'd2) begin
      entries[wr_ptr_b] <= push_b;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(push_n);
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      fill <= fill + CNT_W'(push_n) - CNT_W'(pop);
    end
  end

endmodule

`default_nettype wire

[sv/char_stream_tokenizer.sv]
// Top level of the character stream tokenizer.
`default_nettype none

// Scans a text one byte per transfer and produces tokens with type, start line, start
// column and length. A byte is taken in the same cycle it is offered whenever the token
// queue has two free slots; the scanner state (mode, line, column, pending length) is
// updated in that cycle and the zero, one or two tokens the byte completes are written
// to a four-entry queue, whose head drives the token channel. The token channel
// delivers one token per cycle while it is ready, so the block then sustains one byte
// per cycle; a run of bytes that each close two tokens is paced by the token channel
// at one token per cycle. Counters are COUNTER_WIDTH bits and saturate; output fields
// carry their low 16 bits. There is no clearing pass after reset.
module char_stream_tokenizer #(
  parameter int COUNTER_WIDTH = 16
) (
  input  logic      clk,
  input  logic      rst,
  cst_char_if.sink  char_in,
  cst_tok_if.source tok_out
);
  import cst_pkg::*;

  localparam int CW = COUNTER_WIDTH;

  typedef logic [CW-1:0] cnt_t;

  typedef enum logic [3:0] {
    MODE_IDLE   = 4'b0001,
    MODE_IDENT  = 4'b0010,
    MODE_NUMBER = 4'b0100,
    MODE_STRING = 4'b1000
  } mode_t;

  function automatic cnt_t sat_add(cnt_t a, cnt_t b);
    logic [CW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CW] ? '1 : s[CW-1:0];
  endfunction

  function automatic logic [OUT_W-1:0] low_bits(cnt_t v);
    logic [CW+OUT_W-1:0] x;
    x = {{OUT_W{1'b0}}, v};
    return x[OUT_W-1:0];
  endfunction

  function automatic tok_t make_tok(logic [TYPE_W-1:0] t, cnt_t ln, cnt_t cl, cnt_t len);
    tok_t r;
    r.token_type  = t;
    r.line_no     = low_bits(ln);
    r.col_no      = low_bits(cl);
    r.tok_len     = low_bits(len);
    r.last_of_run = 1'b0;
    return r;
  endfunction

  localparam cnt_t ONE = cnt_t'(1);

  mode_t       mode, mode_next;
  cnt_t        line_cnt, line_next;
  cnt_t        col, col_next;
  cnt_t        plen, plen_next;

  logic [7:0]  ch;
  logic        accept;
  logic        room2;
  logic        go_idle;
  logic        flushed;
  cnt_t        col1;
  cnt_t        plen_inc;
  logic [TYPE_W-1:0] single_t;
  logic        has_second;
  tok_t        tok_flush, tok_idle;
  tok_t        tok_a, tok_b;
  logic [1:0]  n_tok;

  assign ch             = char_in.ch;
  assign char_in.ready  = room2;
  assign accept         = char_in.valid && room2;
  assign plen_inc       = sat_add(plen, ONE);
  assign single_t       = single_type(ch);

  // Close the token in progress, if this byte ends it
  always_comb begin
    mode_next = mode;
    plen_next = plen;
    go_idle   = 1'b0;
    flushed   = 1'b0;
    col1      = col;
    tok_flush = make_tok(TT_EOF, line_cnt, col, '0);
    unique case (mode)
      MODE_STRING: begin
        if (ch == CH_QUOTE) begin
          tok_flush = make_tok(TT_STRING, line_cnt, col, plen_inc);
          flushed   = 1'b1;
          col1      = sat_add(col, plen_inc);
          mode_next = MODE_IDLE;
          plen_next = '0;
        end else if (ch != CH_NUL) begin
          plen_next = plen_inc;
        end else begin
          // unterminated string closes at the end of text
          tok_flush = make_tok(TT_STRING, line_cnt, col, plen);
          flushed   = 1'b1;
          col1      = sat_add(col, plen);
          mode_next = MODE_IDLE;
          plen_next = '0;
          go_idle   = 1'b1;
        end
      end
      MODE_IDENT: begin
        if (is_letter(ch) || is_digit(ch)) begin
          plen_next = plen_inc;
        end else begin
          tok_flush = make_tok(TT_IDENT, line_cnt, col, plen);
          flushed   = 1'b1;
          col1      = sat_add(col, plen);
          mode_next = MODE_IDLE;
          plen_next = '0;
          go_idle   = 1'b1;
        end
      end
      MODE_NUMBER: begin
        if (is_digit(ch)) begin
          plen_next = plen_inc;
        end else begin
          tok_flush = make_tok(TT_NUMBER, line_cnt, col, plen);
          flushed   = 1'b1;
          col1      = sat_add(col, plen);
          mode_next = MODE_IDLE;
          plen_next = '0;
          go_idle   = 1'b1;
        end
      end
      default: begin
        go_idle = 1'b1;
      end
    endcase
  end

  // Byte seen between tokens: starts a token, emits one, or moves the position
  always_comb begin
    line_next  = line_cnt;
    col_next   = col1;
    has_second = 1'b0;
    tok_idle   = make_tok(TT_EOF, line_cnt, col1, '0);
    if (go_idle) begin
      if (ch == CH_NUL) begin
        has_second = 1'b1;
        line_next  = ONE;
        col_next   = ONE;
      end else if (ch == CH_NL) begin
        line_next = sat_add(line_cnt, ONE);
        col_next  = ONE;
      end else if ((ch == CH_SPACE) || (ch == CH_TAB) || (ch == CH_CR)) begin
        col_next = sat_add(col1, ONE);
      end else if (single_t != TT_EOF) begin
        has_second = 1'b1;
        tok_idle   = make_tok(single_t, line_cnt, col1, ONE);
        col_next   = sat_add(col1, ONE);
      end else if (ch == CH_QUOTE || is_letter(ch) || is_digit(ch)) begin
        // token start; the column stays at its first byte
        col_next = col1;
      end else begin
        // unknown byte is a one-byte identifier
        has_second = 1'b1;
        tok_idle   = make_tok(TT_IDENT, line_cnt, col1, ONE);
        col_next   = sat_add(col1, ONE);
      end
    end
  end

  // Start mode and length for a token opened by this byte
  mode_t mode_final;
  cnt_t  plen_final;
  always_comb begin
    mode_final = mode_next;
    plen_final = plen_next;
    if (go_idle) begin
      if (ch == CH_QUOTE) begin
        mode_final = MODE_STRING;
        plen_final = ONE;
      end else if (is_letter(ch)) begin
        mode_final = MODE_IDENT;
        plen_final = ONE;
      end else if (is_digit(ch)) begin
        mode_final = MODE_NUMBER;
        plen_final = ONE;
      end
    end
  end

  // Order the tokens and mark the last one of this byte
  always_comb begin
    tok_a = tok_flush;
    tok_b = tok_idle;
    n_tok = 2'd0;
    if (flushed && has_second) begin
      n_tok             = 2'd2;
      tok_b.last_of_run = 1'b1;
    end else if (flushed) begin
      n_tok             = 2'd1;
      tok_a.last_of_run = 1'b1;
    end else if (has_second) begin
      n_tok             = 2'd1;
      tok_a             = tok_idle;
      tok_a.last_of_run = 1'b1;
    end
  end

  // Scanner state
  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= MODE_IDLE;
      line_cnt <= ONE;
      col      <= ONE;
      plen     <= '0;
    end else if (accept) begin
      mode     <= mode_final;
      line_cnt <= line_next;
      col      <= col_next;
      plen     <= plen_final;
    end
  end

  cst_tok_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push_n  (accept ? n_tok : 2'd0),
    .push_a  (tok_a),
    .push_b  (tok_b),
    .room2   (room2),
    .tok_out (tok_out)
  );

endmodule

`default_nettype wire
